// ===== design/pairwise_particle_force_accumulator_unit_defines.svh =====
// Assertion macros for the pairwise particle force accumulator.
// Included by the modules that assert; depends on clk and rst_n in scope.
`ifndef PAIRWISE_PARTICLE_FORCE_ACCUMULATOR_UNIT_DEFINES_SVH
`define PAIRWISE_PARTICLE_FORCE_ACCUMULATOR_UNIT_DEFINES_SVH
`ifndef SYNTH
`define PPFA_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ppfa assertion failed");
`define PPFA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ppfa assertion failed");
`define PPFA_ASSERT_DLY2(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##2 (cons)) \
        else $error("ppfa assertion failed");
`else
`define PPFA_ASSERT_IMP(lbl, ante, cons)
`define PPFA_ASSERT_NEXT(lbl, ante, cons)
`define PPFA_ASSERT_DLY2(lbl, ante, cons)
`endif
`endif

// ===== design/ppfa_pkg.sv =====
// Types and constants of the pairwise particle force accumulator.
// No dependencies.
package ppfa_pkg;

    localparam int POS_W       = 23;
    localparam int FORCE_W     = 48;
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 104;
    localparam int FUNC_W      = 2;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 32;
    localparam int INDEX_W     = 5;
    localparam int RES_LIMIT   = 32;
    localparam int DVD_W       = 64;
    localparam int R_W         = 24;
    localparam int C_W         = 17;
    localparam int STEP_W      = 4;
    localparam int ITER_W      = 6;
    localparam int ACC_W       = 2 * FORCE_W + 1;
    localparam int COMP_W      = FORCE_W + 2;
    localparam int SUB_W       = 48;

    localparam logic [ITER_W-1:0] DIV_LAST  = 6'd63;
    localparam logic [ITER_W-1:0] SQRT_LAST = 6'd23;
    localparam logic [SUB_W-1:0]  SQRT_BIT0 = 48'h4000_0000_0000;
    localparam logic [FORCE_W-1:0] TERM_CAP = 48'hFFFF_FFFF_FFFF;

    localparam logic [STEP_W-1:0] STEPS_ATTRACT = 4'd6;
    localparam logic [STEP_W-1:0] STEPS_REPEL   = 4'd12;

    localparam logic [CFG_DATA_W-1:0] COEF_ATTRACT_RST = 32'd10250000;
    localparam logic [CFG_DATA_W-1:0] COEF_REPEL_RST   = 32'd726515000;

    localparam logic [CFG_IDX_W-1:0] CFG_MODE         = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_ATTRACT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_REPEL   = 2'd2;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_LOAD_A  = 2'd0,
        FUNC_LOAD_B  = 2'd1,
        FUNC_COMPUTE = 2'd2
    } func_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_CLEAR,
        S_PCHK,
        S_RD1,
        S_RD2,
        S_SQX,
        S_SQY,
        S_SUM,
        S_SQRT,
        S_COS,
        S_DIV,
        S_DDONE,
        S_MUL,
        S_MULD,
        S_AC1R,
        S_AC1W,
        S_AC2W,
        S_PNEXT,
        S_ECHK,
        S_ELD,
        S_EWAIT
    } state_t;

endpackage

// ===== design/ppfa_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module ppfa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/pairwise_particle_force_accumulator_unit.sv =====
// Top level of the pairwise particle force accumulator.
// Depends on ppfa_pkg, ppfa_ram and the assertion macro header.
//
// Usage: the slave stream takes items with tuser = func. A load item (func 0 or
// 1) writes one Q7.16 position into set A or B; a load into a full set is
// dropped. A compute item (func 2) clears the force memory, walks all pairs
// of the active mode and then streams one result per particle on the master
// side: set A in load order, then set B in cross mode, at most 32, with tlast
// on the final one. func 3 is dropped. A coincident pair is skipped; for any
// other pair a bit-serial square root (24 steps) and 38 restoring divisions
// of 64 steps each run through one shared compare-subtract unit, with one
// shared 32x32 multiplier. Each result passes through S_ECHK, S_ELD and
// S_EWAIT and is held in S_EWAIT while the receiver stalls. tready stays low
// from compute start until the last result is taken; a stalled receiver
// holds the result register and the whole block. Reset clears mode and both
// set counts and loads the default coefficients; stored positions persist
// across computes. Configuration writes take effect at once.
`include "pairwise_particle_force_accumulator_unit_defines.svh"

module pairwise_particle_force_accumulator_unit #(
    parameter int MAX_PARTICLES = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // pos_x [22:0], pos_y [45:23], zero [47:46]
    input  logic [ppfa_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // func [1:0]
    input  logic [ppfa_pkg::FUNC_W-1:0]         s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // index [4:0], force_x [52:5], force_y [100:53], zero [103:101]
    output logic [ppfa_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    // which_set [0], saturated [1]
    output logic [1:0]                          m_axis_tuser,
    output logic                                m_axis_tlast,
    input  logic                                cfg_we,
    input  logic [ppfa_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ppfa_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int IW    = $clog2(MAX_PARTICLES);
    localparam int CNW   = $clog2(MAX_PARTICLES + 1);
    localparam int CW    = $clog2(MAX_PARTICLES + 2);
    localparam int SLOTS = 2 * MAX_PARTICLES;
    localparam int SW    = $clog2(SLOTS);
    localparam int TW    = $clog2(SLOTS + 1);
    localparam int PW    = 2 * ppfa_pkg::POS_W;
    localparam int FW    = ppfa_pkg::FORCE_W;
    localparam int VW    = ppfa_pkg::COMP_W;

    // saturating accumulate: returns {clamped, value}
    function automatic logic [FW:0] acc_add(input logic [FW-1:0] acc,
                                            input logic [VW-1:0] v);
        logic [FW+2:0] s;
        logic [FW:0]   r;
        s = {{3{acc[FW-1]}}, acc} + {v[VW-1], v};
        if (!s[FW+2] && (s[FW+1:FW-1] != 3'b000))
        begin
            r = {1'b1, 1'b0, {(FW-1){1'b1}}};
        end
        else if (s[FW+2] && (s[FW+1:FW-1] != 3'b111))
        begin
            r = {1'b1, 1'b1, {(FW-1){1'b0}}};
        end
        else
        begin
            r = {1'b0, s[FW-1:0]};
        end
        return r;
    endfunction

    ppfa_pkg::state_t state_reg, state_next;

    logic                             mode_reg;
    logic [ppfa_pkg::CFG_DATA_W-1:0]  coef_a_reg, coef_r_reg;
    logic [CNW-1:0]                   count_a_reg, count_a_next;
    logic [CNW-1:0]                   count_b_reg, count_b_next;
    logic [CW-1:0]                    j_reg, j_next, k_reg, k_next;
    logic [TW-1:0]                    n_reg, n_next;
    logic [ppfa_pkg::ITER_W-1:0]      it_reg, it_next;
    logic [ppfa_pkg::STEP_W-1:0]      step_reg, step_next;
    logic                             comp_sel_reg, comp_sel_next;
    logic                             term_sel_reg, term_sel_next;
    logic                             div_cos_reg, div_cos_next;
    logic                             out_valid_reg, out_valid_next;

    // datapath registers
    logic [ppfa_pkg::POS_W-1:0]       p1x_reg, p1x_next, p1y_reg, p1y_next;
    logic [ppfa_pkg::POS_W:0]         dx_reg, dx_next, dy_reg, dy_next;
    logic [ppfa_pkg::SUB_W-1:0]       sq_v_reg, sq_v_next;
    logic [ppfa_pkg::SUB_W-1:0]       sq_res_reg, sq_res_next;
    logic [ppfa_pkg::SUB_W-1:0]       sq_bit_reg, sq_bit_next;
    logic [ppfa_pkg::R_W-1:0]         r_reg, r_next;
    logic [ppfa_pkg::R_W-1:0]         rem_reg, rem_next;
    logic [ppfa_pkg::DVD_W-1:0]       dvd_reg, dvd_next, quo_reg, quo_next;
    logic [ppfa_pkg::C_W-1:0]         c_reg, c_next;
    logic [FW-1:0]                    ta_reg, ta_next;
    logic [VW-1:0]                    fx_reg, fx_next, fy_reg, fy_next;
    logic                             pflag_reg, pflag_next;
    logic [2*ppfa_pkg::CFG_DATA_W-1:0] mul_reg;
    logic                             out_set_reg, out_set_next;
    logic [ppfa_pkg::INDEX_W-1:0]     out_index_reg, out_index_next;
    logic [FW-1:0]                    out_fx_reg, out_fx_next, out_fy_reg, out_fy_next;
    logic                             out_sat_reg, out_sat_next;
    logic                             out_last_reg, out_last_next;

    // memories
    logic                        ram_a_we, ram_b_we;
    logic [IW-1:0]               ram_a_raddr, ram_b_raddr;
    logic [PW-1:0]               ram_a_rdata, ram_b_rdata, pos_wdata;
    logic                        acc_we;
    logic [SW-1:0]               acc_waddr, acc_raddr;
    logic [ppfa_pkg::ACC_W-1:0]  acc_wdata, acc_rdata;

    // shared compare-subtract unit
    logic [ppfa_pkg::SUB_W-1:0]  sub_a, sub_b;
    logic [ppfa_pkg::SUB_W:0]    sub_diff;
    logic                        sub_ge;
    logic [ppfa_pkg::R_W:0]      trial;

    // shared multiplier
    logic [ppfa_pkg::CFG_DATA_W-1:0]   mul_a, mul_b;

    logic                        in_acc;
    logic [TW-1:0]               total_raw, total;
    logic                        e_b;
    logic [TW-1:0]               e_idx;
    logic [SW-1:0]               e_slot, i1, i2;
    logic [CNW-1:0]              kend;
    logic [ppfa_pkg::POS_W-1:0]  adx, ady, p2x, p2y;
    logic [ppfa_pkg::POS_W:0]    ndx, ndy;
    logic [FW-1:0]               tq;
    logic                        tq_clamp;
    logic [VW-1:0]               vdiff, comp, acc_v;
    logic [FW:0]                 sum_x, sum_y;
    logic [ppfa_pkg::STEP_W-1:0] nsteps;

    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == ppfa_pkg::S_IDLE);
    assign pos_wdata     = s_axis_tdata[PW-1:0];

    ppfa_ram #(.WIDTH(PW), .DEPTH(MAX_PARTICLES)) u_ram_a (
        .clk   (clk),
        .we    (ram_a_we),
        .waddr (count_a_reg[IW-1:0]),
        .wdata (pos_wdata),
        .raddr (ram_a_raddr),
        .rdata (ram_a_rdata)
    );

    ppfa_ram #(.WIDTH(PW), .DEPTH(MAX_PARTICLES)) u_ram_b (
        .clk   (clk),
        .we    (ram_b_we),
        .waddr (count_b_reg[IW-1:0]),
        .wdata (pos_wdata),
        .raddr (ram_b_raddr),
        .rdata (ram_b_rdata)
    );

    ppfa_ram #(.WIDTH(ppfa_pkg::ACC_W), .DEPTH(SLOTS)) u_ram_acc (
        .clk   (clk),
        .we    (acc_we),
        .waddr (acc_waddr),
        .wdata (acc_wdata),
        .raddr (acc_raddr),
        .rdata (acc_rdata)
    );

    // pair and result addressing
    assign kend      = mode_reg ? count_b_reg : count_a_reg;
    assign i1        = SW'(j_reg[IW-1:0]);
    assign i2        = mode_reg ? (SW'(k_reg[IW-1:0]) + SW'(MAX_PARTICLES))
                                : SW'(k_reg[IW-1:0]);
    assign total_raw = mode_reg ? (TW'(count_a_reg) + TW'(count_b_reg)) : TW'(count_a_reg);
    assign total     = (int'(total_raw) > ppfa_pkg::RES_LIMIT) ? TW'(ppfa_pkg::RES_LIMIT)
                                                                 : total_raw;
    assign e_b       = (n_reg >= TW'(count_a_reg));
    assign e_idx     = e_b ? (n_reg - TW'(count_a_reg)) : n_reg;
    assign e_slot    = e_b ? (SW'(e_idx) + SW'(MAX_PARTICLES)) : SW'(e_idx);

    assign p2x = mode_reg ? ram_b_rdata[ppfa_pkg::POS_W-1:0] : ram_a_rdata[ppfa_pkg::POS_W-1:0];
    assign p2y = mode_reg ? ram_b_rdata[PW-1:ppfa_pkg::POS_W] : ram_a_rdata[PW-1:ppfa_pkg::POS_W];

    assign ndx = 24'd0 - dx_reg;
    assign ndy = 24'd0 - dy_reg;
    assign adx = dx_reg[ppfa_pkg::POS_W] ? ndx[ppfa_pkg::POS_W-1:0] : dx_reg[ppfa_pkg::POS_W-1:0];
    assign ady = dy_reg[ppfa_pkg::POS_W] ? ndy[ppfa_pkg::POS_W-1:0] : dy_reg[ppfa_pkg::POS_W-1:0];

    // shared compare-subtract: square root step or division step
    assign trial = {rem_reg, dvd_reg[ppfa_pkg::DVD_W-1]};
    always_comb
    begin
        if (state_reg == ppfa_pkg::S_SQRT)
        begin
            sub_a = sq_v_reg;
            sub_b = sq_res_reg + sq_bit_reg;
        end
        else
        begin
            sub_a = ppfa_pkg::SUB_W'(trial);
            sub_b = ppfa_pkg::SUB_W'(r_reg);
        end
    end
    assign sub_diff = {1'b0, sub_a} - {1'b0, sub_b};
    assign sub_ge   = !sub_diff[ppfa_pkg::SUB_W];

    // term clamp and pair component
    assign tq_clamp = |quo_reg[ppfa_pkg::DVD_W-1:FW];
    assign tq       = tq_clamp ? ppfa_pkg::TERM_CAP : quo_reg[FW-1:0];
    assign vdiff    = {2'b00, ta_reg} - {2'b00, tq};
    assign comp     = (comp_sel_reg ? dy_reg[ppfa_pkg::POS_W] : dx_reg[ppfa_pkg::POS_W])
                      ? (VW'(0) - vdiff) : vdiff;
    assign nsteps   = term_sel_reg ? ppfa_pkg::STEPS_REPEL : ppfa_pkg::STEPS_ATTRACT;

    // first particle gets +f, second gets -f
    assign acc_v = (state_reg == ppfa_pkg::S_AC2W) ? (VW'(0) - fx_reg) : fx_reg;
    assign sum_x = acc_add(acc_rdata[FW-1:0], acc_v);
    assign sum_y = acc_add(acc_rdata[2*FW-1:FW],
                           (state_reg == ppfa_pkg::S_AC2W) ? (VW'(0) - fy_reg) : fy_reg);

    always_comb
    begin
        state_next     = state_reg;
        count_a_next   = count_a_reg;
        count_b_next   = count_b_reg;
        j_next         = j_reg;
        k_next         = k_reg;
        n_next         = n_reg;
        it_next        = it_reg;
        step_next      = step_reg;
        comp_sel_next  = comp_sel_reg;
        term_sel_next  = term_sel_reg;
        div_cos_next   = div_cos_reg;
        out_valid_next = out_valid_reg;
        p1x_next       = p1x_reg;
        p1y_next       = p1y_reg;
        dx_next        = dx_reg;
        dy_next        = dy_reg;
        sq_v_next      = sq_v_reg;
        sq_res_next    = sq_res_reg;
        sq_bit_next    = sq_bit_reg;
        r_next         = r_reg;
        rem_next       = rem_reg;
        dvd_next       = dvd_reg;
        quo_next       = quo_reg;
        c_next         = c_reg;
        ta_next        = ta_reg;
        fx_next        = fx_reg;
        fy_next        = fy_reg;
        pflag_next     = pflag_reg;
        out_set_next   = out_set_reg;
        out_index_next = out_index_reg;
        out_fx_next    = out_fx_reg;
        out_fy_next    = out_fy_reg;
        out_sat_next   = out_sat_reg;
        out_last_next  = out_last_reg;
        ram_a_we       = 1'b0;
        ram_b_we       = 1'b0;
        ram_a_raddr    = k_reg[IW-1:0];
        ram_b_raddr    = k_reg[IW-1:0];
        acc_we         = 1'b0;
        acc_waddr      = SW'(n_reg);
        acc_wdata      = '0;
        acc_raddr      = e_slot;
        mul_a          = '0;
        mul_b          = '0;

        case (state_reg)
            ppfa_pkg::S_IDLE:
            begin
                if (in_acc)
                begin
                    case (ppfa_pkg::func_t'(s_axis_tuser))
                        ppfa_pkg::FUNC_LOAD_A:
                        begin
                            if (count_a_reg < CNW'(MAX_PARTICLES))
                            begin
                                ram_a_we     = 1'b1;
                                count_a_next = count_a_reg + CNW'(1);
                            end
                        end
                        ppfa_pkg::FUNC_LOAD_B:
                        begin
                            if (count_b_reg < CNW'(MAX_PARTICLES))
                            begin
                                ram_b_we     = 1'b1;
                                count_b_next = count_b_reg + CNW'(1);
                            end
                        end
                        ppfa_pkg::FUNC_COMPUTE:
                        begin
                            n_next     = '0;
                            state_next = ppfa_pkg::S_CLEAR;
                        end
                        default:
                        begin
                            // drop unknown func
                        end
                    endcase
                end
            end

            ppfa_pkg::S_CLEAR:
            begin
                acc_we = 1'b1;
                if (n_reg == TW'(SLOTS - 1))
                begin
                    n_next     = '0;
                    j_next     = '0;
                    k_next     = mode_reg ? CW'(0) : CW'(1);
                    state_next = ppfa_pkg::S_PCHK;
                end
                else
                begin
                    n_next = n_reg + TW'(1);
                end
            end

            ppfa_pkg::S_PCHK:
            begin
                ram_a_raddr = j_reg[IW-1:0];
                if (j_reg >= CW'(count_a_reg))
                begin
                    n_next     = '0;
                    state_next = ppfa_pkg::S_ECHK;
                end
                else if (k_reg >= CW'(kend))
                begin
                    j_next = j_reg + CW'(1);
                    k_next = mode_reg ? CW'(0) : (j_reg + CW'(2));
                end
                else
                begin
                    state_next = ppfa_pkg::S_RD1;
                end
            end

            ppfa_pkg::S_RD1:
            begin
                p1x_next      = ram_a_rdata[ppfa_pkg::POS_W-1:0];
                p1y_next      = ram_a_rdata[PW-1:ppfa_pkg::POS_W];
                comp_sel_next = 1'b0;
                pflag_next    = 1'b0;
                state_next    = ppfa_pkg::S_RD2;
            end

            ppfa_pkg::S_RD2:
            begin
                dx_next    = {1'b0, p1x_reg} - {1'b0, p2x};
                dy_next    = {1'b0, p1y_reg} - {1'b0, p2y};
                state_next = ppfa_pkg::S_SQX;
            end

            ppfa_pkg::S_SQX:
            begin
                mul_a      = 32'(adx);
                mul_b      = 32'(adx);
                state_next = ppfa_pkg::S_SQY;
            end

            ppfa_pkg::S_SQY:
            begin
                mul_a      = 32'(ady);
                mul_b      = 32'(ady);
                sq_v_next  = mul_reg[ppfa_pkg::SUB_W-1:0];
                state_next = ppfa_pkg::S_SUM;
            end

            ppfa_pkg::S_SUM:
            begin
                sq_v_next   = sq_v_reg + mul_reg[ppfa_pkg::SUB_W-1:0];
                sq_res_next = '0;
                sq_bit_next = ppfa_pkg::SQRT_BIT0;
                it_next     = '0;
                // skip coincident pairs
                if ((sq_v_reg + mul_reg[ppfa_pkg::SUB_W-1:0]) == '0)
                begin
                    state_next = ppfa_pkg::S_PNEXT;
                end
                else
                begin
                    state_next = ppfa_pkg::S_SQRT;
                end
            end

            ppfa_pkg::S_SQRT:
            begin
                if (sub_ge)
                begin
                    sq_v_next   = sub_diff[ppfa_pkg::SUB_W-1:0];
                    sq_res_next = (sq_res_reg >> 1) + sq_bit_reg;
                end
                else
                begin
                    sq_res_next = sq_res_reg >> 1;
                end
                sq_bit_next = sq_bit_reg >> 2;
                it_next     = it_reg + 6'd1;
                if (it_reg == ppfa_pkg::SQRT_LAST)
                begin
                    r_next     = sq_res_next[ppfa_pkg::R_W-1:0];
                    state_next = ppfa_pkg::S_COS;
                end
            end

            ppfa_pkg::S_COS:
            begin
                dvd_next     = {25'd0, (comp_sel_reg ? ady : adx), 16'd0};
                rem_next     = '0;
                it_next      = '0;
                div_cos_next = 1'b1;
                state_next   = ppfa_pkg::S_DIV;
            end

            ppfa_pkg::S_DIV:
            begin
                rem_next = sub_ge ? sub_diff[ppfa_pkg::R_W-1:0] : trial[ppfa_pkg::R_W-1:0];
                quo_next = {quo_reg[ppfa_pkg::DVD_W-2:0], sub_ge};
                dvd_next = dvd_reg << 1;
                it_next  = it_reg + 6'd1;
                if (it_reg == ppfa_pkg::DIV_LAST)
                begin
                    state_next = ppfa_pkg::S_DDONE;
                end
            end

            ppfa_pkg::S_DDONE:
            begin
                rem_next = '0;
                it_next  = '0;
                if (div_cos_reg)
                begin
                    c_next        = quo_reg[ppfa_pkg::C_W-1:0];
                    term_sel_next = 1'b0;
                    state_next    = ppfa_pkg::S_MUL;
                end
                else
                begin
                    pflag_next = pflag_reg | tq_clamp;
                    if ((step_reg + 4'd1) < nsteps)
                    begin
                        dvd_next   = {tq, 16'd0};
                        step_next  = step_reg + 4'd1;
                        state_next = ppfa_pkg::S_DIV;
                    end
                    else if (!term_sel_reg)
                    begin
                        ta_next       = tq;
                        term_sel_next = 1'b1;
                        state_next    = ppfa_pkg::S_MUL;
                    end
                    else if (!comp_sel_reg)
                    begin
                        fx_next       = comp;
                        comp_sel_next = 1'b1;
                        state_next    = ppfa_pkg::S_COS;
                    end
                    else
                    begin
                        fy_next    = comp;
                        state_next = ppfa_pkg::S_AC1R;
                    end
                end
            end

            ppfa_pkg::S_MUL:
            begin
                mul_a      = term_sel_reg ? coef_r_reg : coef_a_reg;
                mul_b      = 32'(c_reg);
                state_next = ppfa_pkg::S_MULD;
            end

            ppfa_pkg::S_MULD:
            begin
                dvd_next     = {mul_reg[FW-1:0], 16'd0};
                step_next    = '0;
                rem_next     = '0;
                it_next      = '0;
                div_cos_next = 1'b0;
                state_next   = ppfa_pkg::S_DIV;
            end

            ppfa_pkg::S_AC1R:
            begin
                acc_raddr  = i1;
                state_next = ppfa_pkg::S_AC1W;
            end

            ppfa_pkg::S_AC1W:
            begin
                acc_raddr  = i2;
                acc_we     = 1'b1;
                acc_waddr  = i1;
                acc_wdata  = {acc_rdata[2*FW] | pflag_reg | sum_x[FW] | sum_y[FW],
                              sum_y[FW-1:0], sum_x[FW-1:0]};
                state_next = ppfa_pkg::S_AC2W;
            end

            ppfa_pkg::S_AC2W:
            begin
                acc_we     = 1'b1;
                acc_waddr  = i2;
                acc_wdata  = {acc_rdata[2*FW] | pflag_reg | sum_x[FW] | sum_y[FW],
                              sum_y[FW-1:0], sum_x[FW-1:0]};
                state_next = ppfa_pkg::S_PNEXT;
            end

            ppfa_pkg::S_PNEXT:
            begin
                k_next     = k_reg + CW'(1);
                state_next = ppfa_pkg::S_PCHK;
            end

            ppfa_pkg::S_ECHK:
            begin
                if (n_reg >= total)
                begin
                    state_next = ppfa_pkg::S_IDLE;
                end
                else
                begin
                    state_next = ppfa_pkg::S_ELD;
                end
            end

            ppfa_pkg::S_ELD:
            begin
                out_valid_next = 1'b1;
                out_set_next   = e_b;
                out_index_next = ppfa_pkg::INDEX_W'(e_idx);
                out_fx_next    = acc_rdata[FW-1:0];
                out_fy_next    = acc_rdata[2*FW-1:FW];
                out_sat_next   = acc_rdata[2*FW];
                out_last_next  = ((n_reg + TW'(1)) == total);
                state_next     = ppfa_pkg::S_EWAIT;
            end

            ppfa_pkg::S_EWAIT:
            begin
                // hold the result until the receiver takes it
                if (m_axis_tready)
                begin
                    out_valid_next = 1'b0;
                    n_next         = n_reg + TW'(1);
                    state_next     = ppfa_pkg::S_ECHK;
                end
            end

            default:
            begin
                state_next = ppfa_pkg::S_IDLE;
            end
        endcase
    end

    // control state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ppfa_pkg::S_IDLE;
            mode_reg      <= 1'b0;
            coef_a_reg    <= ppfa_pkg::COEF_ATTRACT_RST;
            coef_r_reg    <= ppfa_pkg::COEF_REPEL_RST;
            count_a_reg   <= '0;
            count_b_reg   <= '0;
            j_reg         <= '0;
            k_reg         <= '0;
            n_reg         <= '0;
            it_reg        <= '0;
            step_reg      <= '0;
            comp_sel_reg  <= 1'b0;
            term_sel_reg  <= 1'b0;
            div_cos_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_a_reg   <= count_a_next;
            count_b_reg   <= count_b_next;
            j_reg         <= j_next;
            k_reg         <= k_next;
            n_reg         <= n_next;
            it_reg        <= it_next;
            step_reg      <= step_next;
            comp_sel_reg  <= comp_sel_next;
            term_sel_reg  <= term_sel_next;
            div_cos_reg   <= div_cos_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    ppfa_pkg::CFG_MODE:         mode_reg   <= cfg_data[0];
                    ppfa_pkg::CFG_COEF_ATTRACT: coef_a_reg <= cfg_data;
                    ppfa_pkg::CFG_COEF_REPEL:   coef_r_reg <= cfg_data;
                    default:
                    begin
                        // drop writes beyond the register list
                    end
                endcase
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        p1x_reg       <= p1x_next;
        p1y_reg       <= p1y_next;
        dx_reg        <= dx_next;
        dy_reg        <= dy_next;
        sq_v_reg      <= sq_v_next;
        sq_res_reg    <= sq_res_next;
        sq_bit_reg    <= sq_bit_next;
        r_reg         <= r_next;
        rem_reg       <= rem_next;
        dvd_reg       <= dvd_next;
        quo_reg       <= quo_next;
        c_reg         <= c_next;
        ta_reg        <= ta_next;
        fx_reg        <= fx_next;
        fy_reg        <= fy_next;
        pflag_reg     <= pflag_next;
        mul_reg       <= {32'd0, mul_a} * {32'd0, mul_b};
        out_set_reg   <= out_set_next;
        out_index_reg <= out_index_next;
        out_fx_reg    <= out_fx_next;
        out_fy_reg    <= out_fy_next;
        out_sat_reg   <= out_sat_next;
        out_last_reg  <= out_last_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'b000, out_fy_reg, out_fx_reg, out_index_reg};
    assign m_axis_tuser  = {out_sat_reg, out_set_reg};
    assign m_axis_tlast  = out_last_reg;

    `PPFA_ASSERT_IMP(a_out_only_in_wait, m_axis_tvalid, state_reg == ppfa_pkg::S_EWAIT)
    `PPFA_ASSERT_DLY2(a_last_frees_input, m_axis_tvalid && m_axis_tready && m_axis_tlast, s_axis_tready)
    `PPFA_ASSERT_IMP(a_div_rem_below_r, state_reg == ppfa_pkg::S_DIV, rem_reg < r_reg)
    `PPFA_ASSERT_IMP(a_count_a_bound, 1'b1, count_a_reg <= CNW'(MAX_PARTICLES))
    `PPFA_ASSERT_NEXT(a_compute_clears, in_acc && (s_axis_tuser == ppfa_pkg::FUNC_COMPUTE), state_reg == ppfa_pkg::S_CLEAR)

endmodule
